>>> rtl/chd_pkg.sv
`timescale 1ns / 1ps
package chd_pkg;

   localparam logic [2:0] KIND_VLEN  = 3'd0;
   localparam logic [2:0] KIND_VEND  = 3'd1;
   localparam logic [2:0] KIND_COUNT = 3'd2;
   localparam logic [2:0] KIND_CLEN  = 3'd3;
   localparam logic [2:0] KIND_NAME  = 3'd4;
   localparam logic [2:0] KIND_SEP   = 3'd5;
   localparam logic [2:0] KIND_VALUE = 3'd6;
   localparam logic [2:0] KIND_TRAIL = 3'd7;

   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       pkt_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [2:0]  byte_kind;
      logic [31:0] comment_index;
      logic        comment_end;
      logic        comment_ok;
      logic        list_done;
      logic        trunc_error;
   } rsp_type;

endpackage

>>> rtl/comment_header_deframer.sv
`timescale 1ns / 1ps
// Comment header deframer.
// Input channel: push/full with req_word (one packet byte and its last flag).
// A word is taken on a clock edge with push high and full low.
// Result channel: empty/pop with rsp_word. While empty is low the oldest
// result is on rsp_word; it is taken on an edge with pop high.
// Every input word yields exactly one result word: the byte, its kind, the
// comment index and the comment end/ok, list done and truncation flags.
// A result is written into the result queue when its byte is taken and is
// on rsp_word once older ones are taken. Throughput: one word per cycle
// while full is low; parser state updates per byte, so bytes go back to back.
// A QUEUE_DEPTH-entry result queue sits between the parser and the result
// port. When the receiver stalls the queue fills, full rises and input is
// held off; nothing is dropped.
// The last flag returns the parser to its start state after that byte.
// Reset (synchronous) empties the queue and returns the parser to the
// vendor length word.
module comment_header_deframer
   import chd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_word,
   output logic    full,
   output rsp_type rsp_word,
   output logic    empty,
   input  logic    pop
);

   logic    take;
   rsp_type parsed;

   assign take = push && !full;

   chd_front u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_word),
      .rsp   (parsed)
   );

   chd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (take),
      .wr_data (parsed),
      .rd_en   (pop),
      .rd_data (rsp_word),
      .full    (full),
      .empty   (empty)
   );

endmodule

>>> rtl/chd_front.sv
`timescale 1ns / 1ps
module chd_front
   import chd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    take,
   input  req_type req,
   output rsp_type rsp
);

   localparam logic [2:0] PH_VLEN  = 3'd0;
   localparam logic [2:0] PH_VEND  = 3'd1;
   localparam logic [2:0] PH_COUNT = 3'd2;
   localparam logic [2:0] PH_CLEN  = 3'd3;
   localparam logic [2:0] PH_BODY  = 3'd4;
   localparam logic [2:0] PH_TRAIL = 3'd5;

   localparam logic [7:0] NAME_LO  = 8'h20;
   localparam logic [7:0] NAME_HI  = 8'h7D;
   localparam logic [7:0] SEP_CHAR = 8'h3D;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  pos_ff, pos_in;
   logic [23:0] accum_ff, accum_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [31:0] comments_left_ff, comments_left_in;
   logic [31:0] count_ff, count_in;
   logic        sep_ff, sep_in;
   logic        nul_ff, nul_in;
   logic        legal_ff, legal_in;

   logic        word_done;
   logic [31:0] word;
   logic [31:0] bytes_dec;
   logic [31:0] comments_dec;
   logic [7:0]  b;

   assign b            = req.pkt_byte;
   assign word_done    = (pos_ff == 2'd3);
   assign word         = {b, accum_ff};
   assign bytes_dec    = (bytes_left_ff == 32'd0) ? 32'd0 : bytes_left_ff - 32'd1;
   assign comments_dec = (comments_left_ff == 32'd0) ? 32'd0 : comments_left_ff - 32'd1;

   always_comb begin
      phase_in         = phase_ff;
      pos_in           = pos_ff;
      accum_in         = accum_ff;
      bytes_left_in    = bytes_left_ff;
      comments_left_in = comments_left_ff;
      count_in         = count_ff;
      sep_in           = sep_ff;
      nul_in           = nul_ff;
      legal_in         = legal_ff;

      rsp               = '0;
      rsp.out_byte      = b;
      rsp.byte_kind     = KIND_TRAIL;

      unique case (pos_ff)
         2'd0: accum_in[7:0]   = b;
         2'd1: accum_in[15:8]  = b;
         2'd2: accum_in[23:16] = b;
         default: ;
      endcase

      unique case (phase_ff)
         PH_VLEN: begin
            rsp.byte_kind = KIND_VLEN;
            pos_in = pos_ff + 2'd1;
            if (word_done) begin
               bytes_left_in = word;
               phase_in = (word == 32'd0) ? PH_COUNT : PH_VEND;
            end
         end
         PH_VEND: begin
            rsp.byte_kind = KIND_VEND;
            bytes_left_in = bytes_dec;
            if (bytes_dec == 32'd0) begin
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            rsp.byte_kind = KIND_COUNT;
            pos_in = pos_ff + 2'd1;
            if (word_done) begin
               comments_left_in = word;
               count_in = 32'd0;
               if (word == 32'd0) begin
                  rsp.list_done = 1'b1;
                  phase_in = PH_TRAIL;
               end else begin
                  phase_in = PH_CLEN;
               end
            end
         end
         PH_CLEN: begin
            rsp.byte_kind     = KIND_CLEN;
            rsp.comment_index = count_ff;
            pos_in = pos_ff + 2'd1;
            if (word_done) begin
               bytes_left_in = word;
               sep_in   = 1'b0;
               nul_in   = 1'b0;
               legal_in = 1'b1;
               if (word == 32'd0) begin
                  rsp.comment_end  = 1'b1;
                  count_in         = count_ff + 32'd1;
                  comments_left_in = comments_dec;
                  if (comments_dec == 32'd0) begin
                     rsp.list_done = 1'b1;
                     phase_in = PH_TRAIL;
                  end else begin
                     phase_in = PH_CLEN;
                  end
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            rsp.comment_index = count_ff;
            if (sep_ff) begin
               rsp.byte_kind = KIND_VALUE;
            end else if (b == SEP_CHAR && !nul_ff) begin
               rsp.byte_kind = KIND_SEP;
               sep_in = 1'b1;
            end else begin
               rsp.byte_kind = KIND_NAME;
               if (b == 8'd0) begin
                  nul_in = 1'b1;
               end
               if (b < NAME_LO || b > NAME_HI) begin
                  legal_in = 1'b0;
               end
            end
            bytes_left_in = bytes_dec;
            if (bytes_dec == 32'd0) begin
               rsp.comment_end  = 1'b1;
               rsp.comment_ok   = sep_in && legal_in;
               count_in         = count_ff + 32'd1;
               comments_left_in = comments_dec;
               if (comments_dec == 32'd0) begin
                  rsp.list_done = 1'b1;
                  phase_in = PH_TRAIL;
               end else begin
                  phase_in = PH_CLEN;
               end
            end
         end
         default: begin
            phase_in = PH_TRAIL;
         end
      endcase

      if (req.pkt_last) begin
         rsp.trunc_error  = (phase_in != PH_TRAIL);
         phase_in         = PH_VLEN;
         pos_in           = 2'd0;
         accum_in         = '0;
         bytes_left_in    = '0;
         comments_left_in = '0;
         count_in         = '0;
         sep_in           = 1'b0;
         nul_in           = 1'b0;
         legal_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_VLEN;
         pos_ff           <= 2'd0;
         accum_ff         <= '0;
         bytes_left_ff    <= '0;
         comments_left_ff <= '0;
         count_ff         <= '0;
         sep_ff           <= 1'b0;
         nul_ff           <= 1'b0;
         legal_ff         <= 1'b1;
      end else if (take) begin
         phase_ff         <= phase_in;
         pos_ff           <= pos_in;
         accum_ff         <= accum_in;
         bytes_left_ff    <= bytes_left_in;
         comments_left_ff <= comments_left_in;
         count_ff         <= count_in;
         sep_ff           <= sep_in;
         nul_ff           <= nul_in;
         legal_ff         <= legal_in;
      end
   end

endmodule

>>> rtl/chd_queue.sv
`timescale 1ns / 1ps
module chd_queue
   import chd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  rsp_type wr_data,
   input  logic    rd_en,
   output rsp_type rd_data,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   rsp_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_wr;
   logic             do_rd;

   assign full    = (cnt_ff == FULL_CNT);
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CNT_ONE;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> rtl/chd_checker.sv
`timescale 1ns / 1ps
module chd_checker
   import chd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input rsp_type rsp_word,
   input logic    empty,
   input logic    pop
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("queue not empty after reset");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("full and empty together");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> !empty)
      else $error("accepted word lost");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_word)))
      else $error("stalled result changed");

   a_ok_needs_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.comment_ok) |-> rsp_word.comment_end)
      else $error("comment ok without comment end");

endmodule

bind comment_header_deframer chd_checker u_chd_checker (.*);
